// File: design/prpi_pkg.sv
// ----------------------------------------------------------------------------
// prpi_pkg
// shared types and constants of the fixed-point pagerank unit
// ----------------------------------------------------------------------------
package prpi_pkg;

    localparam int MAX_NODES = 64;
    localparam int IDX_W     = $clog2(MAX_NODES);
    localparam int N_W       = $clog2(MAX_NODES + 1);
    localparam int RANK_W    = 25;
    localparam int CNT_W     = 8;
    localparam int ITER_W    = 8;
    localparam int DAMP_W    = 17;
    localparam int ACC_W     = 31;
    localparam int PROD_W    = 48;
    localparam int DIV_W     = 32;
    localparam int DSR_W     = 8;
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;

    localparam logic [RANK_W-1:0] ONE_Q24   = RANK_W'(1 << 24);
    localparam logic [DAMP_W-1:0] ONE_Q16   = DAMP_W'(1 << 16);
    localparam logic [CNT_W-1:0]  MAX_COUNT = '1;
    localparam logic [N_W-1:0]    MIN_N     = N_W'(2);
    localparam logic [N_W-1:0]    MAX_N     = N_W'(MAX_NODES);

    typedef enum logic [1:0] {
        REG_NODE_COUNT = 2'd0,
        REG_ITER_COUNT = 2'd1,
        REG_DAMPING    = 2'd2,
        REG_NONE       = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        DIV_INIT = 2'd0,
        DIV_QUOT = 2'd1,
        DIV_TELE = 2'd2
    } t_div_sel;

    typedef struct packed {
        logic             cmd;
        logic [IDX_W-1:0] from_node;
        logic [IDX_W-1:0] to_node;
    } t_in_word;

    typedef struct packed {
        logic [IDX_W-1:0]  node_index;
        logic [RANK_W-1:0] rank_value;
        logic              last_rank;
    } t_out_word;

    typedef struct packed {
        logic             edge_rd;
        logic             edge_wr;
        logic             init_wr;
        logic             div_go;
        t_div_sel         div_sel;
        logic             sum_clr;
        logic             rank_rd;
        logic             tele_mul;
        logic             row_rd;
        logic             acc_clr;
        logic             q_rd;
        logic             dmul;
        logic             nxt_wr;
        logic             bank_flip;
        logic             out_rd;
        logic             out_ld;
        logic             out_last;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] jdx;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic out_vld;
    } t_stat;

endpackage

// File: design/pagerank_power_iteration_unit.sv
// ----------------------------------------------------------------------------
// pagerank_power_iteration_unit
// dense fixed-point pagerank with edge loading and rank read-out
// ----------------------------------------------------------------------------
// input channel: one word per edge (cmd 0) or a start request (cmd 1), taken
// when i_in_valid is high and o_in_stall is low
// an edge word passes through a read state and a write state and produces nothing
// a start word resets the ranks to 1/n and runs the configured iterations;
// each iteration uses the shared 32-step divider once per column quotient and
// once for the teleport term, then reads one quotient per cycle in the row sums
// then n rank words leave on the output channel, node 0 first, last_rank set
// on node n-1; a new word is loaded only after the previous one has gone
// the output word sits in a register; while i_out_stall is high it holds and
// the block waits; no new input word is taken until the last rank has gone
// configuration over the apb port is to be written while the block is idle; the
// block doesn't enforce it; reset clears the adjacency and count stores at once
// and restores the register defaults (64 nodes, 20 iterations, damping 0.85)
// ----------------------------------------------------------------------------
module pagerank_power_iteration_unit
    import prpi_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  t_in_word          i_in_word,
    output logic              o_in_stall,
    output logic              o_out_valid,
    output t_out_word         o_out_word,
    input  logic              i_out_stall,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic [N_W-1:0]    r_node_count;
    logic [ITER_W-1:0] r_iter_count;
    logic [DAMP_W-1:0] r_damping;
    t_reg_idx          w_reg;
    logic [N_W-1:0]    w_n;
    logic [DAMP_W-1:0] w_damp;
    t_cmd              w_cmd;
    t_stat             w_stat;

    assign w_reg  = t_reg_idx'(paddr[3:2]);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= N_W'(64);
            r_iter_count <= ITER_W'(20);
            r_damping    <= DAMP_W'(55706);
        end else if (psel && penable && pwrite) begin
            unique case (w_reg)
                REG_NODE_COUNT: r_node_count <= pwdata[N_W-1:0];
                REG_ITER_COUNT: r_iter_count <= pwdata[ITER_W-1:0];
                REG_DAMPING:    r_damping    <= pwdata[DAMP_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg)
            REG_NODE_COUNT: prdata = DATA_W'(r_node_count);
            REG_ITER_COUNT: prdata = DATA_W'(r_iter_count);
            REG_DAMPING:    prdata = DATA_W'(r_damping);
            default:        prdata = '0;
        endcase
    end

    assign w_n    = (r_node_count < MIN_N) ? MIN_N :
                    (r_node_count > MAX_N) ? MAX_N : r_node_count;
    assign w_damp = (r_damping > ONE_Q16) ? ONE_Q16 : r_damping;

    prpi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_word  (i_in_word),
        .o_in_stall (o_in_stall),
        .i_n        (w_n),
        .i_iters    (r_iter_count),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    prpi_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_n         (w_n),
        .i_damp      (w_damp),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule

// File: design/prpi_div.sv
// ----------------------------------------------------------------------------
// prpi_div
// restoring divider, one quotient bit per cycle, small divisor
// ----------------------------------------------------------------------------
module prpi_div
    import prpi_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_go,
    input  logic [DIV_W-1:0] i_dividend,
    input  logic [DSR_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DIV_W-1:0] o_quot
);

    localparam int STEP_W = $clog2(DIV_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [DSR_W-1:0]  r_dsr;
    logic [DSR_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_q;
    logic [DSR_W:0]    w_trial;
    logic              w_fit;
    logic [DSR_W:0]    w_diff;

    assign w_trial = {r_rem, r_q[DIV_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_dsr});
    assign w_diff  = w_trial - {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_step <= '1;
            end else if (r_busy) begin
                r_step <= r_step - STEP_W'(1);
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_dsr <= i_divisor;
            r_rem <= '0;
            r_q   <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_fit ? w_diff[DSR_W-1:0] : w_trial[DSR_W-1:0];
            r_q   <= {r_q[DIV_W-2:0], w_fit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// File: design/prpi_dpath.sv
// ----------------------------------------------------------------------------
// prpi_dpath
// graph stores, rank memories, accumulators, multipliers and output register
// ----------------------------------------------------------------------------
module prpi_dpath
    import prpi_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    input  logic [N_W-1:0]    i_n,
    input  logic [DAMP_W-1:0] i_damp,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output t_out_word         o_out_word
);

    logic [MAX_NODES-1:0] adj_mem  [MAX_NODES];
    logic [CNT_W-1:0]     cnt_mem  [MAX_NODES];
    logic [RANK_W-1:0]    quot_mem [MAX_NODES];
    logic [RANK_W-1:0]    rk_mem   [2*MAX_NODES];

    logic [MAX_NODES-1:0] r_adj_vld;
    logic [MAX_NODES-1:0] r_cnt_vld;
    logic                 r_bank;
    logic [MAX_NODES-1:0] r_row;
    logic [CNT_W-1:0]     r_cnt_q;
    logic [RANK_W-1:0]    r_rank_q;
    logic [RANK_W-1:0]    r_quot_q;
    logic                 r_qsel;
    logic                 r_qv;
    logic [ACC_W-1:0]     r_sum;
    logic [ACC_W-1:0]     r_acc;
    logic [PROD_W-1:0]    r_tprod;
    logic [PROD_W-1:0]    r_dprod;
    logic [RANK_W-1:0]    r_init;
    logic [RANK_W-1:0]    r_tele;
    t_div_sel             r_div_sel;
    logic [IDX_W-1:0]     r_div_idx;
    logic                 r_out_vld;
    t_out_word            r_out;

    logic [IDX_W-1:0]     w_cnt_addr;
    logic [DIV_W-1:0]     w_dividend;
    logic [DSR_W-1:0]     w_divisor;
    logic                 w_div_done;
    logic [DIV_W-1:0]     w_quot;
    logic [DIV_W:0]       w_val;
    logic [RANK_W-1:0]    w_new_rank;
    logic                 w_rk_we;
    logic [IDX_W:0]       w_rk_waddr;
    logic [RANK_W-1:0]    w_rk_wdata;

    always_comb begin
        w_dividend = '0;
        w_divisor  = DSR_W'(i_n);
        unique case (i_cmd.div_sel)
            DIV_INIT: w_dividend = DIV_W'(ONE_Q24);
            DIV_QUOT: begin
                w_dividend = DIV_W'(r_rank_q);
                w_divisor  = r_cnt_q;
            end
            DIV_TELE: w_dividend = r_tprod[PROD_W-1:16];
            default:  w_dividend = '0;
        endcase
    end

    prpi_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (i_cmd.div_go),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    assign w_cnt_addr = i_cmd.edge_rd ? i_cmd.jdx : i_cmd.idx;
    assign w_val      = (DIV_W+1)'(r_dprod[PROD_W-1:16]) + (DIV_W+1)'(r_tele);
    assign w_new_rank = (w_val > (DIV_W+1)'(ONE_Q24)) ? ONE_Q24 : w_val[RANK_W-1:0];

    assign w_rk_we    = i_cmd.init_wr | i_cmd.nxt_wr;
    assign w_rk_waddr = i_cmd.init_wr ? {r_bank, i_cmd.idx} : {~r_bank, i_cmd.idx};
    assign w_rk_wdata = i_cmd.init_wr ? r_init : w_new_rank;

    // graph stores
    always_ff @(posedge i_clk) begin
        if (i_cmd.edge_rd || i_cmd.row_rd) begin
            r_row <= r_adj_vld[i_cmd.idx] ? adj_mem[i_cmd.idx] : '0;
        end
        if (i_cmd.edge_rd || i_cmd.rank_rd) begin
            r_cnt_q <= r_cnt_vld[w_cnt_addr] ? cnt_mem[w_cnt_addr] : '0;
        end
        if (i_cmd.edge_wr) begin
            adj_mem[i_cmd.idx] <= r_row | (MAX_NODES'(1) << i_cmd.jdx);
            cnt_mem[i_cmd.jdx] <= (r_cnt_q == MAX_COUNT) ? r_cnt_q : r_cnt_q + CNT_W'(1);
        end
    end

    // rank and quotient memories
    always_ff @(posedge i_clk) begin
        if (w_rk_we) begin
            rk_mem[w_rk_waddr] <= w_rk_wdata;
        end
        if (i_cmd.rank_rd || i_cmd.out_rd) begin
            r_rank_q <= rk_mem[{r_bank, i_cmd.idx}];
        end
        if (w_div_done && r_div_sel == DIV_QUOT) begin
            quot_mem[r_div_idx] <= (r_cnt_q == '0) ? '0 : w_quot[RANK_W-1:0];
        end
        if (i_cmd.q_rd) begin
            r_quot_q <= quot_mem[i_cmd.jdx];
            r_qsel   <= r_row[i_cmd.jdx];
        end
    end

    // arithmetic
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_go) begin
            r_div_sel <= i_cmd.div_sel;
            r_div_idx <= i_cmd.idx;
        end
        if (w_div_done) begin
            case (r_div_sel)
                DIV_INIT: r_init <= w_quot[RANK_W-1:0];
                DIV_TELE: r_tele <= w_quot[RANK_W-1:0];
                default:  ;
            endcase
        end
        if (i_cmd.sum_clr) begin
            r_sum <= '0;
        end else if (i_cmd.div_go && i_cmd.div_sel == DIV_QUOT) begin
            r_sum <= r_sum + ACC_W'(r_rank_q);
        end
        if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (r_qv && r_qsel) begin
            r_acc <= r_acc + ACC_W'(r_quot_q);
        end
        if (i_cmd.tele_mul) begin
            r_tprod <= PROD_W'(ONE_Q16 - i_damp) * PROD_W'(r_sum);
        end
        if (i_cmd.dmul) begin
            r_dprod <= PROD_W'(i_damp) * PROD_W'(r_acc);
        end
        if (i_cmd.out_ld) begin
            r_out.node_index <= i_cmd.idx;
            r_out.rank_value <= r_rank_q;
            r_out.last_rank  <= i_cmd.out_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adj_vld <= '0;
            r_cnt_vld <= '0;
            r_bank    <= 1'b0;
            r_qv      <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_qv <= i_cmd.q_rd;
            if (i_cmd.edge_wr) begin
                r_adj_vld[i_cmd.idx] <= 1'b1;
                r_cnt_vld[i_cmd.jdx] <= 1'b1;
            end
            if (i_cmd.bank_flip) begin
                r_bank <= ~r_bank;
            end
            if (i_cmd.out_ld) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && !i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_stat.div_done = w_div_done;
    assign o_stat.out_vld  = r_out_vld;
    assign o_out_valid     = r_out_vld;
    assign o_out_word      = r_out;

endmodule

// File: design/prpi_ctrl.sv
// ----------------------------------------------------------------------------
// prpi_ctrl
// sequencer for edge loading, power iterations and rank read-out
// ----------------------------------------------------------------------------
module prpi_ctrl
    import prpi_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  t_in_word          i_in_word,
    output logic              o_in_stall,
    input  logic [N_W-1:0]    i_n,
    input  logic [ITER_W-1:0] i_iters,
    input  t_stat             i_stat,
    output t_cmd              o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_EDGE_RD,
        S_EDGE_WR,
        S_INIT_WAIT,
        S_INIT_WR,
        S_IT_CHK,
        S_Q_RD,
        S_Q_WAIT,
        S_T_MUL,
        S_T_WAIT,
        S_R_RD,
        S_R_ACC,
        S_R_LAST,
        S_R_MUL,
        S_R_WR,
        S_OUT_RD,
        S_OUT_LD,
        S_OUT_WAIT
    } t_state;

    t_state            r_state, n_state;
    t_cmd              r_cmd, n_cmd;
    logic [IDX_W-1:0]  r_i, n_i;
    logic [IDX_W-1:0]  r_j, n_j;
    logic [ITER_W-1:0] r_it, n_it;
    logic              w_last_i;
    logic              w_last_j;
    logic              w_accept;

    assign w_last_i = ({1'b0, r_i} == i_n - N_W'(1));
    assign w_last_j = ({1'b0, r_j} == i_n - N_W'(1));
    assign w_accept = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_cmd   = '0;
        n_i     = r_i;
        n_j     = r_j;
        n_it    = r_it;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_i = i_in_word.from_node;
                    n_j = i_in_word.to_node;
                    if (i_in_word.cmd) begin
                        n_it          = '0;
                        n_cmd.div_go  = 1'b1;
                        n_cmd.div_sel = DIV_INIT;
                        n_state       = S_INIT_WAIT;
                    end else begin
                        n_cmd.edge_rd = 1'b1;
                        n_cmd.idx     = i_in_word.from_node;
                        n_cmd.jdx     = i_in_word.to_node;
                        n_state       = S_EDGE_RD;
                    end
                end
            end
            S_EDGE_RD: begin
                n_cmd.edge_wr = 1'b1;
                n_cmd.idx     = r_i;
                n_cmd.jdx     = r_j;
                n_state       = S_EDGE_WR;
            end
            S_EDGE_WR: begin
                n_state = S_IDLE;
            end
            S_INIT_WAIT: begin
                if (i_stat.div_done) begin
                    n_i           = '0;
                    n_cmd.init_wr = 1'b1;
                    n_cmd.idx     = '0;
                    n_state       = S_INIT_WR;
                end
            end
            S_INIT_WR: begin
                if (w_last_i) begin
                    n_state = S_IT_CHK;
                end else begin
                    n_i           = r_i + IDX_W'(1);
                    n_cmd.init_wr = 1'b1;
                    n_cmd.idx     = r_i + IDX_W'(1);
                end
            end
            S_IT_CHK: begin
                n_i = '0;
                n_j = '0;
                if (r_it == i_iters) begin
                    n_cmd.out_rd = 1'b1;
                    n_cmd.idx    = '0;
                    n_state      = S_OUT_RD;
                end else begin
                    n_cmd.sum_clr = 1'b1;
                    n_cmd.rank_rd = 1'b1;
                    n_cmd.idx     = '0;
                    n_state       = S_Q_RD;
                end
            end
            S_Q_RD: begin
                n_cmd.div_go  = 1'b1;
                n_cmd.div_sel = DIV_QUOT;
                n_cmd.idx     = r_j;
                n_state       = S_Q_WAIT;
            end
            S_Q_WAIT: begin
                if (i_stat.div_done) begin
                    if (w_last_j) begin
                        n_cmd.tele_mul = 1'b1;
                        n_state        = S_T_MUL;
                    end else begin
                        n_j           = r_j + IDX_W'(1);
                        n_cmd.rank_rd = 1'b1;
                        n_cmd.idx     = r_j + IDX_W'(1);
                        n_state       = S_Q_RD;
                    end
                end
            end
            S_T_MUL: begin
                n_cmd.div_go  = 1'b1;
                n_cmd.div_sel = DIV_TELE;
                n_state       = S_T_WAIT;
            end
            S_T_WAIT: begin
                if (i_stat.div_done) begin
                    n_i           = '0;
                    n_cmd.row_rd  = 1'b1;
                    n_cmd.acc_clr = 1'b1;
                    n_cmd.idx     = '0;
                    n_state       = S_R_RD;
                end
            end
            S_R_RD: begin
                n_j        = '0;
                n_cmd.q_rd = 1'b1;
                n_cmd.jdx  = '0;
                n_state    = S_R_ACC;
            end
            S_R_ACC: begin
                if (w_last_j) begin
                    n_state = S_R_LAST;
                end else begin
                    n_j        = r_j + IDX_W'(1);
                    n_cmd.q_rd = 1'b1;
                    n_cmd.jdx  = r_j + IDX_W'(1);
                end
            end
            S_R_LAST: begin
                n_cmd.dmul = 1'b1;
                n_state    = S_R_MUL;
            end
            S_R_MUL: begin
                n_cmd.nxt_wr = 1'b1;
                n_cmd.idx    = r_i;
                n_state      = S_R_WR;
            end
            S_R_WR: begin
                if (w_last_i) begin
                    n_it            = r_it + ITER_W'(1);
                    n_cmd.bank_flip = 1'b1;
                    n_state         = S_IT_CHK;
                end else begin
                    n_i           = r_i + IDX_W'(1);
                    n_cmd.row_rd  = 1'b1;
                    n_cmd.acc_clr = 1'b1;
                    n_cmd.idx     = r_i + IDX_W'(1);
                    n_state       = S_R_RD;
                end
            end
            S_OUT_RD: begin
                n_cmd.out_ld   = 1'b1;
                n_cmd.idx      = r_i;
                n_cmd.out_last = w_last_i;
                n_state        = S_OUT_LD;
            end
            S_OUT_LD: begin
                n_state = S_OUT_WAIT;
            end
            S_OUT_WAIT: begin
                if (!i_stat.out_vld) begin
                    if (w_last_i) begin
                        n_state = S_IDLE;
                    end else begin
                        n_i          = r_i + IDX_W'(1);
                        n_cmd.out_rd = 1'b1;
                        n_cmd.idx    = r_i + IDX_W'(1);
                        n_state      = S_OUT_RD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cmd   <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_it    <= '0;
        end else begin
            r_state <= n_state;
            r_cmd   <= n_cmd;
            r_i     <= n_i;
            r_j     <= n_j;
            r_it    <= n_it;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_cmd      = r_cmd;

endmodule
